/* sv/mhid_pkg.sv */
// ----------------------------------------------------------------------------
// mhid_pkg: types and constants of the binary min-heap
// Payload structs, status codes and default capacity.
// ----------------------------------------------------------------------------
package mhid_pkg;

    localparam int DefCapacity = 16;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_count;
        logic               min_valid;
        logic signed [31:0] min_value;
    } rsp_t;

endpackage

/* sv/min_heap_insert_delete.sv */
// ----------------------------------------------------------------------------
// min_heap_insert_delete: binary min-heap with insert and delete by value
// Sequencer drives one store read port and one signed comparator.
// ----------------------------------------------------------------------------
// An insert into a full heap goes straight to the root read and the strobe; otherwise
// it is written last and each parent is sifted down in the rebuild, swap by swap.
// A delete searches the entries in order and swaps the last entry into the match;
// a delete that misses searches every held entry. Busy stays high through the strobe;
// the next start is taken at the end of the cycle after it. The receiver cannot stall.
// Reset clears the count and sequencer; store contents stay undefined.
module min_heap_insert_delete
    import mhid_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_SWA   = 4'd3;
    localparam logic [3:0] S_SWB   = 4'd4;
    localparam logic [3:0] S_NEXT  = 4'd5;
    localparam logic [3:0] S_RDN   = 4'd6;
    localparam logic [3:0] S_RDL   = 4'd7;
    localparam logic [3:0] S_RDR   = 4'd8;
    localparam logic [3:0] S_DEC   = 4'd9;
    localparam logic [3:0] S_XB    = 4'd10;
    localparam logic [3:0] S_RROOT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_q;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wa;
    logic signed [31:0] wd;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      node_reg, node_next;
    logic [IW-1:0]      best_reg, best_next;
    logic signed [31:0] nv_reg, nv_next;
    logic signed [31:0] bv_reg, bv_next;
    logic signed [31:0] val_reg, val_next;
    logic [1:0]         st_reg, st_next;
    logic signed [31:0] a_op, b_op;
    logic               lt;
    logic [IW-1:0]      lft, rgt;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_q <= mem[rd_addr];
    end

    assign lt  = a_op < b_op;
    assign lft = {node_reg[IW-2:0], 1'b1};
    assign rgt = {node_reg[IW-2:0], 1'b0} + IW'(2);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        node_next  = node_reg;
        best_next  = best_reg;
        nv_next    = nv_reg;
        bv_next    = bv_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        rd_addr    = AW'(node_reg);
        we         = 1'b0;
        wa         = AW'(node_reg);
        wd         = val_reg;
        a_op       = rd_q;
        b_op       = bv_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next  = req.value;
                    st_next   = ST_DONE;
                    node_next = '0;
                    if (req.kind == KIND_INSERT)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_RROOT;
                        end
                        else
                        begin
                            we         = 1'b1;
                            wa         = AW'(cnt_reg);
                            wd         = req.value;
                            cnt_next   = cnt_reg + CW'(1);
                            k_next     = IW'((cnt_reg + CW'(1)) >> 1);
                            state_next = S_NEXT;
                        end
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (node_reg >= IW'(cnt_reg))
                begin
                    st_next    = ST_NOT_FOUND;
                    state_next = S_RROOT;
                end
                else
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (rd_q == val_reg)
                begin
                    best_next  = IW'(cnt_reg - CW'(1));
                    nv_next    = rd_q;
                    rd_addr    = AW'(cnt_reg - CW'(1));
                    state_next = S_SWA;
                end
                else
                begin
                    node_next  = node_reg + IW'(1);
                    state_next = S_SRCH;
                end
            end
            S_SWA:
            begin
                rd_addr    = AW'(best_reg);
                state_next = S_SWB;
            end
            S_SWB:
            begin
                we         = 1'b1;
                wa         = AW'(node_reg);
                wd         = rd_q;
                cnt_next   = cnt_reg - CW'(1);
                k_next     = IW'((cnt_reg - CW'(1)) >> 1);
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_RROOT;
                end
                else
                begin
                    k_next     = k_reg - IW'(1);
                    node_next  = k_reg - IW'(1);
                    rd_addr    = AW'(k_reg - IW'(1));
                    state_next = S_RDN;
                end
            end
            S_RDN:
            begin
                nv_next    = rd_q;
                bv_next    = rd_q;
                best_next  = node_reg;
                rd_addr    = AW'(lft);
                state_next = (lft < IW'(cnt_reg)) ? S_RDL : S_NEXT;
            end
            S_RDL:
            begin
                if (lt)
                begin
                    bv_next   = rd_q;
                    best_next = lft;
                end
                rd_addr    = AW'(rgt);
                state_next = (rgt < IW'(cnt_reg)) ? S_RDR : S_DEC;
            end
            S_RDR:
            begin
                if (lt)
                begin
                    bv_next   = rd_q;
                    best_next = rgt;
                end
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (best_reg == node_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    we         = 1'b1;
                    wa         = AW'(best_reg);
                    wd         = nv_reg;
                    state_next = S_XB;
                end
            end
            S_XB:
            begin
                we         = 1'b1;
                wa         = AW'(node_reg);
                wd         = bv_reg;
                node_next  = best_reg;
                rd_addr    = AW'(best_reg);
                state_next = S_RDN;
            end
            S_RROOT:
            begin
                rd_addr    = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        node_reg <= node_next;
        best_reg <= best_next;
        nv_reg   <= nv_next;
        bv_reg   <= bv_next;
        val_reg  <= val_next;
        st_reg   <= st_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);
    assign rsp.status      = st_reg;
    assign rsp.entry_count = 5'(cnt_reg);
    assign rsp.min_valid   = (cnt_reg != '0);
    assign rsp.min_value   = (cnt_reg != '0) ? rd_q : 32'sd0;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY)) else $error("count above capacity");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_full_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (done && st_reg == ST_FULL) |-> cnt_reg == CW'(CAPACITY))
        else $error("full status with room");
    a_start_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
